/* hdl/phce_pkg.sv */
// Package for the pixel hit cluster encoder: word kinds, field widths and defaults.
package phce_pkg;

    // Field widths of one input item and one output word
    localparam int ENCODER_W    = 4;
    localparam int ADDR_W       = 10;
    localparam int WORD_MAP_W   = 7;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    // Default cluster window after the base address
    localparam int HITMAP_BITS_DEFAULT = 7;

    // Input operation codes (travel on s_tuser)
    typedef enum logic {
        OP_HIT = 1'b0,
        OP_EOR = 1'b1
    } op_t;

    // Output word kinds (travel on m_tuser)
    typedef enum logic [1:0] {
        KIND_SHORT   = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_TRAILER = 2'd2
    } word_kind_t;

endpackage

/* hdl/pixel_hit_cluster_encoder_top.sv */
// Pixel hit cluster encoder: groups neighboring hits of one encoder into short/long words.
//
// Usage:
//   Slave channel (s_*): one item is a pixel hit (s_tuser = 0, encoder number and
//   pixel address in s_tdata) or an end-of-region marker (s_tuser = 1).
//   Master channel (m_*): data words (short or long) and the region trailer; the
//   kind is on m_tuser, m_tlast marks the last word caused by one input item.
//   cfg_wr_en / cfg_wr_data write clustering_enable; write it only while idle.
// Timing:
//   An accepted item is held in the input register; any word it yields is loaded into the
//   output register when it is processed, which waits for the output and any queued trailer.
//   One item per cycle is sustained while m_tready stays high; an end-of-region that flushes
//   an open cluster yields two words and holds off the next item until the trailer is loaded.
// Reset:
//   rst_n clears both registers' valid flags and the open cluster; clustering is
//   enabled after reset.
// Stall:
//   While m_tready is low the output word holds and the input register still
//   takes one more item; after that s_tready drops until the output drains.
module pixel_hit_cluster_encoder_top #(
    parameter int HITMAP_BITS = phce_pkg::HITMAP_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: clustering_enable
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [phce_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] encoder_num, [13:4] pixel_addr
    input  logic                           s_tuser,  // [0] operation
    // Output words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [phce_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] encoder, [13:4] base, [20:14] hitmap
    output logic [1:0]                     m_tuser,  // [1:0] word_kind
    output logic                           m_tlast   // last
);

    localparam int EXT_W  = (HITMAP_BITS > phce_pkg::WORD_MAP_W) ?
                            HITMAP_BITS : phce_pkg::WORD_MAP_W;
    localparam int DIFF_W = phce_pkg::ADDR_W + 1;

    // Configuration register
    logic enable_reg;

    // Input register
    logic                            in_valid_reg;
    phce_pkg::op_t                   in_op_reg;
    logic [phce_pkg::ENCODER_W-1:0]  in_enc_reg;
    logic [phce_pkg::ADDR_W-1:0]     in_addr_reg;

    // Cluster state
    logic                            cluster_open_reg, cluster_open_next;
    logic [phce_pkg::ENCODER_W-1:0]  cluster_enc_reg, cluster_enc_next;
    logic [phce_pkg::ADDR_W-1:0]     cluster_base_reg, cluster_base_next;
    logic [HITMAP_BITS-1:0]          cluster_map_reg, cluster_map_next;

    // Output register and queued trailer
    logic                            out_valid_reg, out_valid_next;
    phce_pkg::word_kind_t            out_kind_reg, out_kind_next;
    logic [phce_pkg::ENCODER_W-1:0]  out_enc_reg, out_enc_next;
    logic [phce_pkg::ADDR_W-1:0]     out_base_reg, out_base_next;
    logic [phce_pkg::WORD_MAP_W-1:0] out_map_reg, out_map_next;
    logic                            out_last_reg, out_last_next;
    logic                            trail_pend_reg, trail_pend_next;

    logic                            advance;
    logic                            out_take;
    logic [DIFF_W-1:0]               diff;
    logic [HITMAP_BITS-1:0]          hit_bit;
    logic                            in_window;
    logic                            window_end;
    logic [HITMAP_BITS-1:0]          joined_map;
    logic [EXT_W-1:0]                map_ext;
    logic [EXT_W-1:0]                joined_ext;
    phce_pkg::word_kind_t            flush_kind;
    phce_pkg::word_kind_t            joined_kind;

    // Handshake: process the held item when the output stage can take a word and no trailer is queued
    assign out_take = m_tvalid && m_tready;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready) && !trail_pend_reg;
    assign s_tready = !in_valid_reg || advance;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            enable_reg <= cfg_wr_data;
        end
    end

    // Capture an input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= phce_pkg::op_t'(s_tuser);
            in_enc_reg  <= s_tdata[phce_pkg::ENCODER_W-1:0];
            in_addr_reg <= s_tdata[phce_pkg::ENCODER_W +: phce_pkg::ADDR_W];
        end
    end

    // Window test: address minus base, one-hot bit for the new hit
    assign diff = {1'b0, in_addr_reg} - {1'b0, cluster_base_reg};

    always_comb
    begin
        for (int i = 0; i < HITMAP_BITS; i++)
        begin
            hit_bit[i] = (diff == DIFF_W'(i + 1));
        end
    end

    assign in_window  = (in_enc_reg == cluster_enc_reg) && (hit_bit != '0);
    assign window_end = hit_bit[HITMAP_BITS-1];
    assign joined_map = cluster_map_reg | hit_bit;
    assign map_ext    = EXT_W'(cluster_map_reg);
    assign joined_ext = EXT_W'(joined_map);
    assign flush_kind  = (cluster_map_reg != '0) ? phce_pkg::KIND_LONG : phce_pkg::KIND_SHORT;
    assign joined_kind = (joined_map != '0) ? phce_pkg::KIND_LONG : phce_pkg::KIND_SHORT;

    // Next cluster state and output word
    always_comb
    begin
        cluster_open_next = cluster_open_reg;
        cluster_enc_next  = cluster_enc_reg;
        cluster_base_next = cluster_base_reg;
        cluster_map_next  = cluster_map_reg;
        out_valid_next    = out_valid_reg;
        out_kind_next     = out_kind_reg;
        out_enc_next      = out_enc_reg;
        out_base_next     = out_base_reg;
        out_map_next      = out_map_reg;
        out_last_next     = out_last_reg;
        trail_pend_next   = trail_pend_reg;

        if (advance)
        begin
            // Preload the flush cluster word, not valid by default; arms below override
            out_valid_next = 1'b0;
            out_kind_next  = flush_kind;
            out_enc_next   = cluster_enc_reg;
            out_base_next  = cluster_base_reg;
            out_map_next   = map_ext[phce_pkg::WORD_MAP_W-1:0];
            out_last_next  = 1'b1;
            priority if (in_op_reg == phce_pkg::OP_EOR)
            begin
                cluster_open_next = 1'b0;
                cluster_map_next  = '0;
                out_valid_next    = 1'b1;
                if (cluster_open_reg)
                begin
                    out_last_next   = 1'b0;
                    trail_pend_next = 1'b1;
                end
                else
                begin
                    out_kind_next = phce_pkg::KIND_TRAILER;
                    out_enc_next  = '0;
                    out_base_next = '0;
                    out_map_next  = '0;
                end
            end
            else if (!enable_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = phce_pkg::KIND_SHORT;
                out_enc_next   = in_enc_reg;
                out_base_next  = in_addr_reg;
                out_map_next   = '0;
            end
            else if (!cluster_open_reg)
            begin
                cluster_open_next = 1'b1;
                cluster_enc_next  = in_enc_reg;
                cluster_base_next = in_addr_reg;
                cluster_map_next  = '0;
            end
            else if (in_window)
            begin
                cluster_map_next = joined_map;
                if (window_end)
                begin
                    // Last window bit hit: send the long word early and close
                    out_valid_next    = 1'b1;
                    out_kind_next     = joined_kind;
                    out_map_next      = joined_ext[phce_pkg::WORD_MAP_W-1:0];
                    cluster_open_next = 1'b0;
                    cluster_map_next  = '0;
                end
            end
            else
            begin
                // Hit outside the window: flush and start a new cluster
                out_valid_next    = 1'b1;
                cluster_open_next = 1'b1;
                cluster_enc_next  = in_enc_reg;
                cluster_base_next = in_addr_reg;
                cluster_map_next  = '0;
            end
        end
        else if (out_take)
        begin
            if (trail_pend_reg)
            begin
                // Load the queued trailer behind the flushed cluster
                out_kind_next   = phce_pkg::KIND_TRAILER;
                out_enc_next    = '0;
                out_base_next   = '0;
                out_map_next    = '0;
                out_last_next   = 1'b1;
                trail_pend_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_open_reg <= 1'b0;
            cluster_enc_reg  <= '0;
            cluster_base_reg <= '0;
            cluster_map_reg  <= '0;
            out_valid_reg    <= 1'b0;
            trail_pend_reg   <= 1'b0;
        end
        else
        begin
            cluster_open_reg <= cluster_open_next;
            cluster_enc_reg  <= cluster_enc_next;
            cluster_base_reg <= cluster_base_next;
            cluster_map_reg  <= cluster_map_next;
            out_valid_reg    <= out_valid_next;
            trail_pend_reg   <= trail_pend_next;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_enc_reg  <= out_enc_next;
        out_base_reg <= out_base_next;
        out_map_reg  <= out_map_next;
        out_last_reg <= out_last_next;
    end

    // Drive the master channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_map_reg, out_base_reg, out_enc_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A queued trailer always sits behind a word in the output register
    a_pend_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        trail_pend_reg |-> (out_valid_reg && !out_last_reg))
        else $error("trailer queued without a flushed cluster word ahead");

    // Nothing is processed while a trailer is still queued
    a_no_advance_pend: assert property (@(posedge clk) disable iff (!rst_n)
        trail_pend_reg |-> !advance)
        else $error("item processed while trailer queued");

    // A closed cluster carries no hitmap bits
    a_closed_map_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !cluster_open_reg |-> (cluster_map_reg == '0))
        else $error("hitmap bits left in a closed cluster");

    // A waiting trailer means the region's cluster is closed
    a_trailer_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == phce_pkg::KIND_TRAILER) |-> !cluster_open_reg)
        else $error("cluster open while region trailer pending");

    // A queued trailer is presented right after the flushed word leaves
    a_trailer_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (trail_pend_reg && m_tready) |=>
            (out_valid_reg && out_kind_reg == phce_pkg::KIND_TRAILER && out_last_reg))
        else $error("queued trailer not presented after flush word");
`endif

endmodule

/* verif/cluster_word_sb_pkg.sv */
// Scoreboard class for the cluster encoder: predicts output words and checks the DUT's words.
package cluster_word_sb_pkg;

    import phce_pkg::*;

    // Cluster window of the DUT instance under test
    localparam int HITMAP_BITS = HITMAP_BITS_DEFAULT;

    // One output word as it should appear on the master channel
    typedef struct packed {
        word_kind_t              kind;
        logic [ENCODER_W-1:0]    encoder;
        logic [ADDR_W-1:0]       base;
        logic [WORD_MAP_W-1:0]   hitmap;
        logic                    last;
    } cluster_word_t;

    class cluster_word_scoreboard;

        cluster_word_t           pending_words[$];
        int                      failures;

        // Shadow copy of the register and the open cluster
        bit                      clustering_en;
        bit                      cluster_open;
        logic [ENCODER_W-1:0]    cluster_enc;
        logic [ADDR_W-1:0]       cluster_base;
        logic [15:0]             cluster_map;

        function new();
            failures      = 0;
            clustering_en = 1'b1;
            cluster_open  = 1'b0;
            cluster_enc   = '0;
            cluster_base  = '0;
            cluster_map   = '0;
        endfunction

        function void set_clustering(bit value);
            clustering_en = value;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void push_word(word_kind_t kind, logic [ENCODER_W-1:0] enc,
                                logic [ADDR_W-1:0] base, logic [15:0] map, logic last);
            cluster_word_t w;
            w.kind    = kind;
            w.encoder = enc;
            w.base    = base;
            w.hitmap  = map[WORD_MAP_W-1:0];
            w.last    = last;
            pending_words.push_back(w);
        endfunction

        // Emit the open cluster, short when nothing joined it
        function void flush_cluster(logic last);
            push_word((cluster_map == '0) ? KIND_SHORT : KIND_LONG,
                      cluster_enc, cluster_base, cluster_map, last);
            cluster_open = 1'b0;
        endfunction

        function void open_cluster(logic [ENCODER_W-1:0] enc, logic [ADDR_W-1:0] addr);
            cluster_open = 1'b1;
            cluster_enc  = enc;
            cluster_base = addr;
            cluster_map  = '0;
        endfunction

        // Predict the words caused by one accepted item
        function void note_item(op_t op, logic [ENCODER_W-1:0] enc, logic [ADDR_W-1:0] addr);
            int pos;
            if (op == OP_EOR) begin
                if (cluster_open)
                    flush_cluster(1'b0);
                push_word(KIND_TRAILER, '0, '0, '0, 1'b1);
                cluster_open = 1'b0;
                cluster_map  = '0;
            end
            else if (!clustering_en) begin
                // open cluster stays untouched while clustering is off
                push_word(KIND_SHORT, enc, addr, '0, 1'b1);
            end
            else if (!cluster_open) begin
                open_cluster(enc, addr);
            end
            else if (enc == cluster_enc && int'(addr) > int'(cluster_base) &&
                     int'(addr) <= int'(cluster_base) + HITMAP_BITS) begin
                pos = int'(addr) - int'(cluster_base) - 1;
                cluster_map[pos] = 1'b1;
                // last window bit closes the cluster early
                if (pos == HITMAP_BITS - 1)
                    flush_cluster(1'b1);
            end
            else begin
                flush_cluster(1'b1);
                open_cluster(enc, addr);
            end
        endfunction

        // Compare one accepted output word with the oldest prediction
        function void check_word(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
            cluster_word_t exp_w;
            logic [ENCODER_W-1:0]  got_enc;
            logic [ADDR_W-1:0]     got_base;
            logic [WORD_MAP_W-1:0] got_map;
            got_enc  = tdata[ENCODER_W-1:0];
            got_base = tdata[ENCODER_W+ADDR_W-1:ENCODER_W];
            got_map  = tdata[ENCODER_W+ADDR_W+WORD_MAP_W-1:ENCODER_W+ADDR_W];
            if (pending_words.size() == 0) begin
                if (failures < 10)
                    $display("unexpected word: kind=%0d enc=%0d base=%0d map=%h last=%0d",
                             tuser, got_enc, got_base, got_map, tlast);
                failures++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (tuser !== exp_w.kind || got_enc !== exp_w.encoder ||
                got_base !== exp_w.base || got_map !== exp_w.hitmap ||
                tlast !== exp_w.last) begin
                if (failures < 10)
                    $display("word mismatch: expected kind=%0d enc=%0d base=%0d map=%h last=%0d, got kind=%0d enc=%0d base=%0d map=%h last=%0d",
                             exp_w.kind, exp_w.encoder, exp_w.base, exp_w.hitmap, exp_w.last,
                             tuser, got_enc, got_base, got_map, tlast);
                failures++;
            end
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
// Testbench top for the pixel hit cluster encoder: directed and random regions, scoreboard check.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import phce_pkg::*;
    import cluster_word_sb_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1450;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    cluster_word_scoreboard sb;
    int                     items_sent;
    int                     burst_left;
    int                     cycle_count;

    pixel_hit_cluster_encoder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser, m_tlast);
    end

    // Receiver back-pressure: switch between stall patterns
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit level;
        m_tready  = 1'b0;
        mode_left = 0;
        hold_left = 0;
        level     = 1'b1;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 99) < 85);
                default:
                begin
                    // long stalls with short open windows
                    if (hold_left == 0)
                    begin
                        level     = !level;
                        hold_left = level ? $urandom_range(1, 5) : $urandom_range(5, 30);
                    end
                    hold_left--;
                    m_tready <= level;
                end
            endcase
        end
    end

    // Drive one item and hold it until accepted; gaps fall between bursts
    task automatic send_item(op_t op, logic [ENCODER_W-1:0] enc, logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-ENCODER_W-ADDR_W){1'b0}}, addr, enc};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, enc, addr);
        items_sent++;
    endtask

    // Hold off input until every predicted word has come and the pipeline is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clustering(bit value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_clustering(value);
    endtask

    // One region: hits walking up through encoders and addresses, then end of region.
    // An untidy region may repeat or step back an address and may lack its end marker.
    task automatic send_region(bit tidy);
        int nhits;
        int enc;
        int addr;
        int pick;
        int i;
        nhits = $urandom_range(0, 20);
        enc   = $urandom_range(0, 15);
        addr  = $urandom_range(0, 1023);
        for (i = 0; i < nhits; i++)
        begin
            send_item(OP_HIT, enc[ENCODER_W-1:0], addr[ADDR_W-1:0]);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                addr += int'($urandom_range(1, HITMAP_BITS + 1));
            else if (pick < 75)
                addr += int'($urandom_range(HITMAP_BITS + 2, 64));
            else if (pick < 88 || tidy)
            begin
                enc += 1;
                addr = $urandom_range(0, 1023);
            end
            else
                addr -= int'($urandom_range(0, 3));
            if (addr < 0)
                addr = 0;
            if (tidy)
            begin
                // move on to the next encoder past the top address
                if (addr > 1023)
                begin
                    enc += 1;
                    addr = $urandom_range(0, 63);
                end
                if (enc > 15)
                    break;
            end
            else
            begin
                addr = addr & 1023;
                enc  = enc & 15;
            end
        end
        if (tidy || $urandom_range(0, 1))
            send_item(OP_EOR, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
    endtask

    // Main sequence
    initial
    begin : stimulus
        int target;
        int next_cfg;
        int pick;
        int n;
        sb          = new();
        items_sent  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_HIT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_clustering(1'b1);

        // Early close on the last window bit, at the lowest addresses
        send_item(OP_HIT, 4'd0, 10'd0);
        send_item(OP_HIT, 4'd0, 10'd1);
        send_item(OP_HIT, 4'd0, 10'd7);
        // Short flush at end of region, then a trailer with nothing open
        send_item(OP_HIT, 4'd15, 10'd1023);
        send_item(OP_EOR, 4'd0, 10'd0);
        send_item(OP_EOR, 4'd15, 10'd1023);
        // Same address, lower address, one past the window, another encoder
        send_item(OP_HIT, 4'd3, 10'd100);
        send_item(OP_HIT, 4'd3, 10'd100);
        send_item(OP_HIT, 4'd3, 10'd99);
        send_item(OP_HIT, 4'd3, 10'd107);
        send_item(OP_HIT, 4'd4, 10'd108);
        send_item(OP_HIT, 4'd4, 10'd110);
        send_item(OP_HIT, 4'd4, 10'd115);
        send_item(OP_EOR, 4'd0, 10'd0);
        // Long word flushed by end of region at the top address
        send_item(OP_HIT, 4'd9, 10'd1020);
        send_item(OP_HIT, 4'd9, 10'd1023);
        send_item(OP_EOR, 4'd0, 10'd0);
        // Clustering turned off with a cluster open, then back on
        send_item(OP_HIT, 4'd5, 10'd512);
        write_clustering(1'b0);
        send_item(OP_HIT, 4'd5, 10'd513);
        send_item(OP_HIT, 4'd10, 10'd0);
        write_clustering(1'b1);
        send_item(OP_HIT, 4'd5, 10'd514);
        send_item(OP_HIT, 4'd5, 10'd520);
        send_item(OP_EOR, 4'd0, 10'd0);
        // End of region while clustering is off and a cluster is open
        send_item(OP_HIT, 4'd6, 10'd200);
        write_clustering(1'b0);
        send_item(OP_EOR, 4'd0, 10'd0);

        // Random regions in phases of random clustering setting
        target   = items_sent + RANDOM_ITEMS;
        next_cfg = items_sent;
        while (items_sent < target)
        begin
            if (items_sent >= next_cfg)
            begin
                write_clustering($urandom_range(0, 3) != 0);
                next_cfg = items_sent + $urandom_range(100, 250);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_region(1'b1);
            else if (pick < 85)
                send_region(1'b0);
            else if (pick < 97)
            begin
                // loose items with no order at all
                n = $urandom_range(1, 8);
                repeat (n)
                    send_item(($urandom_range(0, 9) == 0) ? OP_EOR : OP_HIT,
                              4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
            end
            else
                wait_idle();
        end

        // Drain and let the pipeline settle
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
